// ===== sv/rhsl_pkg.sv =====
// Shared types and constants for the RGB to HSL pixel converter.
`timescale 1ns / 1ps
`default_nettype none

package rhsl_pkg;

   // Datapath widths
   localparam int CHAN_W   = 8;
   localparam int HUE_W    = 15;
   localparam int FRAC_W   = 16;
   localparam int SUM_W    = 9;
   localparam int HNUM_W   = 23;   // 3840 * numerator, numerator up to 7 * 255
   localparam int SNUM_W   = 24;   // spread * 65535
   localparam int QUOT_W   = 16;   // quotient bits, one per divider stage

   // Pipeline layout
   localparam int FRONT_STAGES = 2;
   localparam int DIV_STAGES   = QUOT_W;
   localparam int NUM_STAGES   = FRONT_STAGES + DIV_STAGES + 1;

   // 360 degrees in 1/64 degree units
   localparam logic [QUOT_W-1:0] HUE_FULL = 16'd23040;

   // Channel that holds the maximum, ties resolved red, green, blue
   typedef enum logic [1:0] {
      SECT_RED,
      SECT_GREEN,
      SECT_BLUE
   } sector_type;

   // Front end result, feeds the dividers
   typedef struct packed {
      logic [CHAN_W-1:0] alpha;
      logic [HNUM_W-1:0] hue_num;
      logic [CHAN_W-1:0] spread;
      logic [SNUM_W-1:0] sat_num;
      logic [CHAN_W-1:0] sat_den;
      logic [FRAC_W-1:0] lightness;
      logic              grey;
   } front_type;

   // Fields carried alongside the divider stages
   typedef struct packed {
      logic [CHAN_W-1:0] alpha;
      logic [FRAC_W-1:0] lightness;
      logic              grey;
   } side_type;

endpackage

`default_nettype wire

// ===== sv/rgb_to_hsl_pixel.sv =====
// Top level of the RGB to HSL pixel converter: pipeline control and output stage.
// Pipeline: 2 front end stages, 16 divider stages at one quotient bit each, and
//   1 output register lie between the input transaction and rsp_valid.
// Throughput: one pixel per cycle when rsp_ready is high; each stage advances
//   when empty or when its successor advances: bubbles collapse, stalls drop nothing.
// Reset clears the stage valid bits only; datapath registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_hsl_pixel (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [rhsl_pkg::CHAN_W-1:0]        req_alpha_in,
   input  logic [rhsl_pkg::CHAN_W-1:0]        req_red,
   input  logic [rhsl_pkg::CHAN_W-1:0]        req_green,
   input  logic [rhsl_pkg::CHAN_W-1:0]        req_blue,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [rhsl_pkg::CHAN_W-1:0]        rsp_alpha_out,
   output logic [rhsl_pkg::HUE_W-1:0]         rsp_hue,
   output logic [rhsl_pkg::FRAC_W-1:0]        rsp_saturation,
   output logic [rhsl_pkg::FRAC_W-1:0]        rsp_lightness
);
   import rhsl_pkg::*;

   localparam int LAST = NUM_STAGES - 1;

   logic [NUM_STAGES-1:0] vld_ff, vld_in, load;
   logic [NUM_STAGES:0]   rdy;
   front_type             front;
   side_type              side_ff [DIV_STAGES];
   logic [QUOT_W-1:0]     hue_quot, sat_quot, hue_wrap;
   logic [CHAN_W-1:0]     alpha_ff, alpha_in;
   logic [HUE_W-1:0]      hue_ff, hue_in;
   logic [FRAC_W-1:0]     sat_ff, sat_in, light_ff, light_in;

   // Stage ready chain, from the output back to the input
   always_comb begin
      rdy[NUM_STAGES] = rsp_ready;
      for (int s = LAST; s >= 0; s--) begin
         rdy[s] = !vld_ff[s] || rdy[s+1];
      end
   end

   // Valid bits travel with the data
   always_comb begin
      for (int s = 0; s < NUM_STAGES; s++) begin
         load[s]   = rdy[s];
         vld_in[s] = (s == 0) ? req_valid : vld_ff[(s == 0) ? 0 : s - 1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int s = 0; s < NUM_STAGES; s++) begin
            if (load[s]) begin
               vld_ff[s] <= vld_in[s];
            end
         end
      end
   end

   assign req_ready = rdy[0];
   assign rsp_valid = vld_ff[LAST];

   // Front end stages
   rhsl_front u_front (
      .clock   (clock),
      .step_en (load[FRONT_STAGES-1:0]),
      .alpha   (req_alpha_in),
      .red     (req_red),
      .green   (req_green),
      .blue    (req_blue),
      .front   (front)
   );

   // Hue: 3840 * numerator / spread
   rhsl_div #(
      .NUM_W (HNUM_W),
      .DEN_W (CHAN_W),
      .Q_W   (QUOT_W)
   ) u_hue_div (
      .clock    (clock),
      .step_en  (load[FRONT_STAGES+DIV_STAGES-1:FRONT_STAGES]),
      .dividend (front.hue_num),
      .divisor  (front.spread),
      .quotient (hue_quot)
   );

   // Saturation: spread * 65535 / (255 - |sum - 255|)
   rhsl_div #(
      .NUM_W (SNUM_W),
      .DEN_W (CHAN_W),
      .Q_W   (QUOT_W)
   ) u_sat_div (
      .clock    (clock),
      .step_en  (load[FRONT_STAGES+DIV_STAGES-1:FRONT_STAGES]),
      .dividend (front.sat_num),
      .divisor  (front.sat_den),
      .quotient (sat_quot)
   );

   // Side fields shadow the divider stages
   always_ff @(posedge clock) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
         if (load[FRONT_STAGES+s]) begin
            if (s == 0) begin
               side_ff[s] <= '{alpha: front.alpha, lightness: front.lightness,
                               grey: front.grey};
            end else begin
               side_ff[s] <= side_ff[(s == 0) ? 0 : s - 1];
            end
         end
      end
   end

   // Output stage: hue wrap at 360 degrees, grey pixels force hue and saturation to 0
   assign hue_wrap = (hue_quot >= HUE_FULL) ? hue_quot - HUE_FULL : hue_quot;

   always_comb begin
      alpha_in = side_ff[DIV_STAGES-1].alpha;
      light_in = side_ff[DIV_STAGES-1].lightness;
      hue_in   = side_ff[DIV_STAGES-1].grey ? '0 : hue_wrap[HUE_W-1:0];
      sat_in   = side_ff[DIV_STAGES-1].grey ? '0 : sat_quot;
   end

   always_ff @(posedge clock) begin
      if (load[LAST]) begin
         alpha_ff <= alpha_in;
         hue_ff   <= hue_in;
         sat_ff   <= sat_in;
         light_ff <= light_in;
      end
   end

   assign rsp_alpha_out  = alpha_ff;
   assign rsp_hue        = hue_ff;
   assign rsp_saturation = sat_ff;
   assign rsp_lightness  = light_ff;

endmodule

`default_nettype wire

// ===== sv/rhsl_front.sv =====
// Front end: max/min search, spread, hue numerator, saturation operands, lightness.
`timescale 1ns / 1ps
`default_nettype none

module rhsl_front (
   input  logic                              clock,
   input  logic [1:0]                        step_en,
   input  logic [rhsl_pkg::CHAN_W-1:0]       alpha,
   input  logic [rhsl_pkg::CHAN_W-1:0]       red,
   input  logic [rhsl_pkg::CHAN_W-1:0]       green,
   input  logic [rhsl_pkg::CHAN_W-1:0]       blue,
   output rhsl_pkg::front_type               front
);
   import rhsl_pkg::*;

   // Stage A registers
   logic [CHAN_W-1:0] alpha_ff, red_ff, green_ff, blue_ff, max_ff, min_ff;
   logic [CHAN_W-1:0] max_in, min_in;
   sector_type        sector_ff, sector_in;

   // Stage B next values
   logic [CHAN_W-1:0] spread;
   logic [SUM_W-1:0]  sum;
   logic [10:0]       spread_w, num;
   front_type         front_in, front_ff;

   // Max channel and sector, red wins ties over green, green over blue
   always_comb begin
      if (red >= green && red >= blue) begin
         sector_in = SECT_RED;
         max_in    = red;
      end else if (green >= blue) begin
         sector_in = SECT_GREEN;
         max_in    = green;
      end else begin
         sector_in = SECT_BLUE;
         max_in    = blue;
      end
      min_in = (red <= green) ? red : green;
      if (blue < min_in) begin
         min_in = blue;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en[0]) begin
         alpha_ff  <= alpha;
         red_ff    <= red;
         green_ff  <= green;
         blue_ff   <= blue;
         max_ff    <= max_in;
         min_ff    <= min_in;
         sector_ff <= sector_in;
      end
   end

   // Spread, sum and the sector numerator (always non-negative)
   assign spread   = max_ff - min_ff;
   assign sum      = {1'b0, max_ff} + {1'b0, min_ff};
   assign spread_w = {3'b000, spread};

   always_comb begin
      case (sector_ff)
         SECT_RED:   num = {3'b000, green_ff} + (spread_w << 2) + (spread_w << 1)
                           - {3'b000, blue_ff};
         SECT_GREEN: num = {3'b000, blue_ff} + (spread_w << 1) - {3'b000, red_ff};
         SECT_BLUE:  num = {3'b000, red_ff} + (spread_w << 2) - {3'b000, green_ff};
         default:    num = '0;
      endcase
   end

   // Constant products by shift and subtract; lightness = 128*sum + sum/2
   always_comb begin
      front_in.alpha     = alpha_ff;
      front_in.hue_num   = {num, 12'b0} - {4'b0000, num, 8'b0};
      front_in.spread    = spread;
      front_in.sat_num   = {spread, 16'b0} - {16'b0, spread};
      front_in.sat_den   = (sum <= SUM_W'(255)) ? sum[CHAN_W-1:0]
                                                : CHAN_W'(SUM_W'(510) - sum);
      front_in.lightness = {sum, 7'b0} + {8'b0, sum[SUM_W-1:1]};
      front_in.grey      = (spread == '0);
   end

   always_ff @(posedge clock) begin
      if (step_en[1]) begin
         front_ff <= front_in;
      end
   end

   assign front = front_ff;

endmodule

`default_nettype wire

// ===== sv/rhsl_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
`timescale 1ns / 1ps
`default_nettype none

module rhsl_div #(
   parameter int NUM_W = 24,
   parameter int DEN_W = 8,
   parameter int Q_W   = 16
) (
   input  logic             clock,
   input  logic [Q_W-1:0]   step_en,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic [Q_W-1:0]   quotient
);
   // Dividend must stay below divisor * 2**Q_W
   localparam int REM_W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

   logic [REM_W-1:0] rem_ff [Q_W];
   logic [DEN_W-1:0] den_ff [Q_W];
   logic [Q_W-1:0]   q_ff   [Q_W];

   genvar i;
   for (i = 0; i < Q_W; i++) begin : g_stage
      logic [REM_W-1:0] rem_src, trial, rem_in;
      logic [DEN_W-1:0] den_in;
      logic [Q_W-1:0]   q_src, q_in;
      logic             take;

      if (i == 0) begin : g_first
         assign rem_src = REM_W'(dividend);
         assign den_in  = divisor;
         assign q_src   = '0;
      end else begin : g_next
         assign rem_src = rem_ff[i-1];
         assign den_in  = den_ff[i-1];
         assign q_src   = q_ff[i-1];
      end

      // Trial subtract of the divisor aligned to this quotient bit
      assign trial  = REM_W'(den_in) << (Q_W - 1 - i);
      assign take   = (rem_src >= trial);
      assign rem_in = take ? rem_src - trial : rem_src;
      assign q_in   = q_src | (Q_W'(take) << (Q_W - 1 - i));

      always_ff @(posedge clock) begin
         if (step_en[i]) begin
            rem_ff[i] <= rem_in;
            den_ff[i] <= den_in;
            q_ff[i]   <= q_in;
         end
      end
   end

   assign quotient = q_ff[Q_W-1];

endmodule

`default_nettype wire
